/* src/tilt_compensated_heading_assert.svh */
// ----------------------------------------------------------------------------
// Tilt-compensated heading: assertion macros
// Shared property forms used by the heading pipeline checks.
// ----------------------------------------------------------------------------
`ifndef TILT_COMPENSATED_HEADING_ASSERT_SVH
`define TILT_COMPENSATED_HEADING_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/tch_pkg.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading package
// Payload types, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tch_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LAST        = 23;

   localparam int SQRT_STEPS = 15;   // one result bit per stage, 29-bit radicand
   localparam int SQ_W       = 31;
   localparam int VEC_W      = 48;   // Xh, Yh at scale 2^28
   localparam int CX_W       = 50;   // CORDIC x/y with growth headroom
   localparam int Z_W        = 36;   // Q2.30 angle with headroom

   localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [15:0]    ONE_Q14     = 16'sd16384;
   localparam logic [15:0]           HEADING_MAX = 16'd51472;
   localparam logic [15:0]           HEADING_PI  = 16'd25736;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] mag_x;
      logic signed [15:0] mag_y;
      logic signed [15:0] mag_z;
   } req_type;

   typedef struct packed {
      logic [15:0] heading;
      logic        tilt_clamped;
   } rsp_type;

   // atan(2^-k) in Q2.30, rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] k);
      logic signed [Z_W-1:0] a;
      case (k)
         5'd0:    a = 36'sd843314857;
         5'd1:    a = 36'sd497837829;
         5'd2:    a = 36'sd263043837;
         5'd3:    a = 36'sd133525159;
         5'd4:    a = 36'sd67021687;
         5'd5:    a = 36'sd33543516;
         5'd6:    a = 36'sd16775851;
         5'd7:    a = 36'sd8388437;
         5'd8:    a = 36'sd4194283;
         5'd9:    a = 36'sd2097149;
         5'd10:   a = 36'sd1048576;
         5'd11:   a = 36'sd524288;
         5'd12:   a = 36'sd262144;
         5'd13:   a = 36'sd131072;
         5'd14:   a = 36'sd65536;
         5'd15:   a = 36'sd32768;
         5'd16:   a = 36'sd16384;
         5'd17:   a = 36'sd8192;
         5'd18:   a = 36'sd4096;
         5'd19:   a = 36'sd2048;
         5'd20:   a = 36'sd1024;
         5'd21:   a = 36'sd512;
         5'd22:   a = 36'sd256;
         default: a = 36'sd128;
      endcase
      return a;
   endfunction

endpackage

/* src/tilt_compensated_heading.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading
// Pipelined compass heading from raw accelerometer and magnetometer counts.
// ----------------------------------------------------------------------------
// Usage: a sample (accel X/Y, mag X/Y/Z) enters on req_valid/req_ready and the
// heading leaves on rsp_valid/rsp_ready, one result item for every item taken.
// The accel gain is written through csr_we/csr_wdata; the user must keep the
// block idle then, as the block does not enforce it. Throughput is one item
// per cycle while the receiver does not stall. From acceptance to rsp_valid,
// three stages scale and clamp the accel values and form 1 - s^2, fifteen
// stages extract the two cosines one root bit at a time, three stages form Xh
// and Yh, one stage folds the vector into the right half plane, one stage per
// CORDIC iteration follows, and a last stage rounds into the output register.
// The whole pipeline advances together whenever the output register is empty
// or its item is being taken, so a sample is accepted in the same cycle that
// a waiting result leaves. When the receiver stalls, every stage holds and
// req_ready drops; nothing is lost or repeated.
// Synchronous reset empties all stages and loads the gain with 65536.
// ----------------------------------------------------------------------------
`include "tilt_compensated_heading_assert.svh"

module tilt_compensated_heading #(
   parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tch_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tch_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [23:0]      csr_wdata
);

   localparam int NS = tch_pkg::SQRT_STEPS;
   localparam int SW = tch_pkg::SQ_W;
   localparam int VW = tch_pkg::VEC_W;
   localparam int CW = tch_pkg::CX_W;
   localparam int ZW = tch_pkg::Z_W;

   typedef struct packed {
      tch_pkg::req_type   item;
      logic signed [15:0] sp;
      logic signed [15:0] sr;
      logic               clamped;
   } side_type;

   // The whole pipeline moves together; the output register parts the sides.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Gain register.
   logic [23:0] gain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= 24'd65536;
      end else if (csr_we) begin
         gain_ff <= csr_wdata;
      end
   end

   // Stage 1: raw accel times gain.
   logic                 s1_vld_ff;
   tch_pkg::req_type     s1_item_ff;
   logic signed [40:0]   s1_px_ff, s1_py_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= req_item;
         s1_px_ff   <= req_item.accel_x * $signed({1'b0, gain_ff});
         s1_py_ff   <= req_item.accel_y * $signed({1'b0, gain_ff});
      end
   end

   // Stage 2: floor shift by sixteen and clamp to unit magnitude.
   logic signed [24:0] s2_fx, s2_fy;
   logic signed [15:0] s2_sp_in, s2_sr_in;
   logic               s2_cx, s2_cy;
   always_comb begin
      s2_fx = s1_px_ff[40:16];
      s2_fy = s1_py_ff[40:16];
      s2_cx = (s2_fx > 25'sd16384) || (s2_fx < -25'sd16384);
      s2_cy = (s2_fy > 25'sd16384) || (s2_fy < -25'sd16384);
      if (s2_fx > 25'sd16384)       s2_sp_in = tch_pkg::ONE_Q14;
      else if (s2_fx < -25'sd16384) s2_sp_in = -tch_pkg::ONE_Q14;
      else                          s2_sp_in = s2_fx[15:0];
      if (s2_fy > 25'sd16384)       s2_sr_in = tch_pkg::ONE_Q14;
      else if (s2_fy < -25'sd16384) s2_sr_in = -tch_pkg::ONE_Q14;
      else                          s2_sr_in = s2_fy[15:0];
   end

   logic     s2_vld_ff;
   side_type s2_side_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_side_ff.item    <= s1_item_ff;
         s2_side_ff.sp      <= s2_sp_in;
         s2_side_ff.sr      <= s2_sr_in;
         s2_side_ff.clamped <= s2_cx || s2_cy;
      end
   end

   // Stage 3: radicands 2^28 - s^2 for both cosines.
   logic signed [31:0] s3_qp, s3_qr;
   assign s3_qp = s2_side_ff.sp * s2_side_ff.sp;
   assign s3_qr = s2_side_ff.sr * s2_side_ff.sr;

   logic                sq_vld_ff  [0:NS];
   side_type            sq_side_ff [0:NS];
   logic [SW-1:0]       sq_v_ff    [0:NS][0:1];
   logic [SW-1:0]       sq_r_ff    [0:NS][0:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= s2_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0]  <= s2_side_ff;
         sq_v_ff[0][0]  <= SW'(32'sd268435456 - s3_qp);
         sq_v_ff[0][1]  <= SW'(32'sd268435456 - s3_qr);
         sq_r_ff[0][0]  <= '0;
         sq_r_ff[0][1]  <= '0;
      end
   end

   // Square root stages: one result bit per stage, both lanes side by side.
   for (genvar j = 0; j < NS; j++) begin : g_sqrt
      localparam logic [SW-1:0] BIT = SW'(1) << (28 - 2 * j);
      logic [SW-1:0] v_in [0:1];
      logic [SW-1:0] r_in [0:1];
      always_comb begin
         for (int l = 0; l < 2; l++) begin
            if (sq_v_ff[j][l] >= sq_r_ff[j][l] + BIT) begin
               v_in[l] = sq_v_ff[j][l] - (sq_r_ff[j][l] + BIT);
               r_in[l] = (sq_r_ff[j][l] >> 1) + BIT;
            end else begin
               v_in[l] = sq_v_ff[j][l];
               r_in[l] = sq_r_ff[j][l] >> 1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[j+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[j+1] <= sq_vld_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_side_ff[j+1] <= sq_side_ff[j];
            sq_v_ff[j+1][0] <= v_in[0];
            sq_v_ff[j+1][1] <= v_in[1];
            sq_r_ff[j+1][0] <= r_in[0];
            sq_r_ff[j+1][1] <= r_in[1];
         end
      end
   end

   // Stage A: first-level products.
   logic signed [15:0] a_cp, a_cr;
   assign a_cp = $signed({1'b0, sq_r_ff[NS][0][14:0]});
   assign a_cr = $signed({1'b0, sq_r_ff[NS][1][14:0]});

   logic               a_vld_ff, a_clamp_ff;
   logic signed [15:0] a_mx_ff, a_mz_ff;
   logic signed [31:0] a_p1_ff, a_p2_ff, a_p3_ff, a_srsp_ff, a_srcp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= sq_vld_ff[NS];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         a_clamp_ff <= sq_side_ff[NS].clamped;
         a_mx_ff    <= sq_side_ff[NS].item.mag_x;
         a_mz_ff    <= sq_side_ff[NS].item.mag_z;
         a_p1_ff    <= sq_side_ff[NS].item.mag_x * a_cp;
         a_p2_ff    <= sq_side_ff[NS].item.mag_z * sq_side_ff[NS].sp;
         a_p3_ff    <= sq_side_ff[NS].item.mag_y * a_cr;
         a_srsp_ff  <= sq_side_ff[NS].sr * sq_side_ff[NS].sp;
         a_srcp_ff  <= sq_side_ff[NS].sr * a_cp;
      end
   end

   // Stage B: Xh and the second-level products of Yh.
   logic               b_vld_ff, b_clamp_ff;
   logic signed [VW-1:0] b_xh_ff, b_t1_ff, b_t3_ff, b_t2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_clamp_ff <= a_clamp_ff;
         b_xh_ff    <= (VW'(a_p1_ff) + VW'(a_p2_ff)) <<< 14;
         b_t1_ff    <= VW'(a_mx_ff * a_srsp_ff);
         b_t3_ff    <= VW'(a_mz_ff * a_srcp_ff);
         b_t2_ff    <= VW'(a_p3_ff) <<< 14;
      end
   end

   // Stage C: Yh.
   logic               c_vld_ff, c_clamp_ff;
   logic signed [VW-1:0] c_xh_ff, c_yh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_clamp_ff <= b_clamp_ff;
         c_xh_ff    <= b_xh_ff;
         c_yh_ff    <= b_t1_ff + b_t2_ff - b_t3_ff;
      end
   end

   // CORDIC stage 0: a vector in the left half plane is turned by pi.
   logic                 cv_vld_ff   [0:CORDIC_STEPS];
   logic                 cv_clamp_ff [0:CORDIC_STEPS];
   logic                 cv_zero_ff  [0:CORDIC_STEPS];
   logic signed [CW-1:0] cv_x_ff     [0:CORDIC_STEPS];
   logic signed [CW-1:0] cv_y_ff     [0:CORDIC_STEPS];
   logic signed [ZW-1:0] cv_z_ff     [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_vld_ff[0] <= c_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         cv_clamp_ff[0] <= c_clamp_ff;
         cv_zero_ff[0]  <= (c_xh_ff == '0) && (c_yh_ff == '0);
         if (c_xh_ff < 0) begin
            cv_x_ff[0] <= -CW'(c_xh_ff);
            cv_y_ff[0] <= -CW'(c_yh_ff);
            cv_z_ff[0] <= (c_yh_ff >= 0) ? tch_pkg::PI_Q30 : -tch_pkg::PI_Q30;
         end else begin
            cv_x_ff[0] <= CW'(c_xh_ff);
            cv_y_ff[0] <= CW'(c_yh_ff);
            cv_z_ff[0] <= '0;
         end
      end
   end

   // One CORDIC vectoring iteration per stage.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam int K = (i > tch_pkg::ATAN_LAST) ? tch_pkg::ATAN_LAST : i;
      logic signed [CW-1:0] xs, ys;
      assign xs = cv_x_ff[i] >>> K;
      assign ys = cv_y_ff[i] >>> K;
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_vld_ff[i+1] <= cv_vld_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cv_clamp_ff[i+1] <= cv_clamp_ff[i];
            cv_zero_ff[i+1]  <= cv_zero_ff[i];
            if (cv_y_ff[i] >= 0) begin
               cv_x_ff[i+1] <= cv_x_ff[i] + ys;
               cv_y_ff[i+1] <= cv_y_ff[i] - xs;
               cv_z_ff[i+1] <= cv_z_ff[i] + tch_pkg::atan_q30(5'(K));
            end else begin
               cv_x_ff[i+1] <= cv_x_ff[i] - ys;
               cv_y_ff[i+1] <= cv_y_ff[i] + xs;
               cv_z_ff[i+1] <= cv_z_ff[i] - tch_pkg::atan_q30(5'(K));
            end
         end
      end
   end

   // Final stage: add pi, round into Q3.13 and clamp. A zero vector gives pi.
   logic signed [ZW-1:0] f_a;
   logic [ZW-1:0]        f_r;
   logic [15:0]          f_h;
   always_comb begin
      f_a = cv_zero_ff[CORDIC_STEPS] ? tch_pkg::PI_Q30
                                     : cv_z_ff[CORDIC_STEPS] + tch_pkg::PI_Q30;
      if (f_a < 0) begin
         f_a = '0;
      end
      f_r = (ZW'(f_a) + ZW'(65536)) >> 17;
      f_h = (f_r > ZW'(tch_pkg::HEADING_MAX)) ? tch_pkg::HEADING_MAX : f_r[15:0];
   end

   logic             out_vld_ff;
   tch_pkg::rsp_type out_item_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= cv_vld_ff[CORDIC_STEPS];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_item_ff.heading      <= f_h;
         out_item_ff.tilt_clamped <= cv_clamp_ff[CORDIC_STEPS];
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_item_ff;

   // Checks.
   `TCH_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready,
      "input not ready while output register is empty")
   `TCH_ASSERT_SAME(a_heading_range, clock, reset, rsp_valid,
      rsp_item.heading <= tch_pkg::HEADING_MAX, "heading out of range")
   `TCH_ASSERT_NEXT(a_zero_vector, clock, reset,
      adv && cv_vld_ff[CORDIC_STEPS] && cv_zero_ff[CORDIC_STEPS],
      rsp_valid && rsp_item.heading == tch_pkg::HEADING_PI,
      "zero vector did not give a heading of pi")
   `TCH_ASSERT_SAME(a_cos_range, clock, reset, sq_vld_ff[NS],
      sq_r_ff[NS][0] <= SW'(16384) && sq_r_ff[NS][1] <= SW'(16384),
      "cosine root above one")

endmodule

/* dv/tb_tilt_compensated_heading.sv */
// ----------------------------------------------------------------------------
// Tilt-compensated heading testbench
// Drives accelerometer and magnetometer samples through the heading pipeline
// under random gaps and stalls, predicts each heading in software and checks
// every result item in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tilt_compensated_heading;

   localparam int  STEPS     = 16;
   localparam int  LATENCY   = 23 + STEPS;
   localparam int  N_RANDOM  = 450;
   localparam longint PI_Q   = 64'sd3373259426;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tch_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tch_pkg::rsp_type rsp_item;
   logic             csr_we = 1'b0;
   logic [23:0]      csr_wdata = '0;

   // The predictor keeps its own copy of the gain register.
   logic [23:0]      gain_shadow = 24'd65536;
   tch_pkg::rsp_type heading_queue[$];
   int               mismatch_count = 0;

   tilt_compensated_heading #(.CORDIC_STEPS(STEPS)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Arithmetic shift of a signed value is a floor division by 2^s.
   function automatic longint floor_div(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r, bit_val;
      r = 0;
      bit_val = 64'd1 << 30;
      while (bit_val > v) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= r + bit_val) begin
            v = v - (r + bit_val);
            r = (r >> 1) + bit_val;
         end else begin
            r = r >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return r;
   endfunction

   function automatic longint arctan_table(int k);
      longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                        524288, 262144, 131072, 65536, 32768, 16384, 8192,
                        4096, 2048, 1024, 512, 256, 128};
      return t[k];
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, xs, ys;
      int k;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_Q : -PI_Q;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         k = (i > 23) ? 23 : i;
         xs = floor_div(x, k);
         ys = floor_div(y, k);
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + arctan_table(k);
         end else begin
            x = x - ys; y = y + xs; z = z - arctan_table(k);
         end
      end
      return z;
   endfunction

   function automatic tch_pkg::rsp_type predict_heading(tch_pkg::req_type s);
      tch_pkg::rsp_type r;
      longint sp, sr, cp, cr, mx, my, mz, xh, yh, a, h;
      r.tilt_clamped = 1'b0;
      sp = floor_div(longint'(s.accel_x) * longint'(gain_shadow), 16);
      sr = floor_div(longint'(s.accel_y) * longint'(gain_shadow), 16);
      if (sp > 16384) begin sp = 16384; r.tilt_clamped = 1'b1; end
      if (sp < -16384) begin sp = -16384; r.tilt_clamped = 1'b1; end
      if (sr > 16384) begin sr = 16384; r.tilt_clamped = 1'b1; end
      if (sr < -16384) begin sr = -16384; r.tilt_clamped = 1'b1; end
      mx = s.mag_x;
      my = s.mag_y;
      mz = s.mag_z;
      cp = int_sqrt(64'sd268435456 - sp * sp);
      cr = int_sqrt(64'sd268435456 - sr * sr);
      xh = (mx * cp + mz * sp) * 16384;
      yh = mx * (sr * sp) + my * cr * 16384 - mz * (sr * cp);
      a = vector_angle(yh, xh) + PI_Q;
      if (a < 0) a = 0;
      h = (a + 65536) >>> 17;
      if (h > 51472) h = 51472;
      r.heading = h[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Sends one sample after a random gap and records its prediction. Valid
   // stays high into the next item when the gap is zero.
   task automatic send_sample(tch_pkg::req_type s);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item  <= s;
      req_valid <= 1'b1;
      heading_queue.push_back(predict_heading(s));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // The receiver draws a stall per item and checks each accepted result.
   initial begin
      int stall;
      tch_pkg::rsp_type want;
      forever begin
         @(negedge clock);
         if (!rsp_ready) begin
            stall = $urandom_range(0, 5);
            repeat (stall) @(negedge clock);
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready && !reset) begin
            if (heading_queue.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = heading_queue.pop_front();
               if (rsp_item.heading !== want.heading)
                  report_mismatch("heading", rsp_item.heading, want.heading);
               if (rsp_item.tilt_clamped !== want.tilt_clamped)
                  report_mismatch("tilt_clamped", rsp_item.tilt_clamped,
                                  want.tilt_clamped);
            end
            #1 rsp_ready <= 1'b0;
         end
      end
   end

   function automatic tch_pkg::req_type make_sample(int ax, int ay, int mx, int my,
                                                    int mz);
      tch_pkg::req_type s;
      s.accel_x = 16'(ax);
      s.accel_y = 16'(ay);
      s.mag_x   = 16'(mx);
      s.mag_y   = 16'(my);
      s.mag_z   = 16'(mz);
      return s;
   endfunction

   function automatic tch_pkg::req_type random_sample();
      return make_sample($urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Ends the current burst, waits until every expected item has arrived,
   // then lets the pipe drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (heading_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_gain(logic [23:0] g);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= g;
      gain_shadow = g;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Extremes of every field, zero vector, negative Xh on both sides of Yh,
   // and clamping in both directions.
   task automatic test_directed();
      send_sample(make_sample(0, 0, 0, 0, 0));
      send_sample(make_sample(0, 0, 100, 0, 0));
      send_sample(make_sample(0, 0, -100, 0, 0));
      send_sample(make_sample(0, 0, -100, -1, 0));
      send_sample(make_sample(0, 0, -100, 1, 0));
      send_sample(make_sample(0, 0, 0, 100, 0));
      send_sample(make_sample(0, 0, 0, -100, 0));
      send_sample(make_sample(32767, 32767, 32767, 32767, 32767));
      send_sample(make_sample(-32768, -32768, -32768, -32768, -32768));
      send_sample(make_sample(16384, -16384, 500, -700, 300));
      send_sample(make_sample(16385, 0, 500, 700, -300));
      send_sample(make_sample(0, -16385, -500, 700, 300));
      send_sample(make_sample(-1, 1, -32768, 0, 32767));
      send_sample(make_sample(8000, -9000, 0, 0, 1000));
      send_sample(make_sample(-32768, 32767, -32768, -1, -32768));
   endtask

   task automatic test_gain_sweep();
      logic [23:0] gains[4] = '{24'd0, 24'hFFFFFF, 24'd1, 24'd40000};
      foreach (gains[i]) begin
         write_gain(gains[i]);
         repeat (6) send_sample(random_sample());
         send_sample(make_sample(0, 0, -5, -5, 5));
         wait_idle();
      end
   endtask

   // Mostly bounded tilt at unit, then random gain, plus full-range noise.
   task automatic test_random();
      tch_pkg::req_type s;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 150 == 0) begin
            wait_idle();
            write_gain(i == 0 ? 24'd65536 : 24'($urandom_range(1000, 200000)));
         end
         s = random_sample();
         if ($urandom_range(0, 3) != 0) begin
            s.accel_x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
            s.accel_y = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
         end
         send_sample(s);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      wait_idle();
      test_gain_sweep();
      test_random();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/tch_pkg.sv
src/tilt_compensated_heading.sv
dv/tb_tilt_compensated_heading.sv
